// ===== sv/lspwe_pkg.sv =====
`default_nettype none

package lspwe_pkg;

    // Sizes and reset values of the encoder.
    localparam int MAX_LEDS_DEF  = 1024;
    localparam int BITS_PER_SLOT = 24;
    localparam int CNT_W         = 5;
    localparam int POS_W         = 11;
    localparam int CFG_W         = 11;
    localparam int CFG_IDX_W     = 2;

    localparam logic [7:0]       HIGH_ONE_RST  = 8'd49;
    localparam logic [7:0]       HIGH_ZERO_RST = 8'd20;
    localparam logic [POS_W-1:0] LED_COUNT_RST = 11'd1024;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_ONE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_ZERO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT = 2'd2;

    // Item kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_SLOT  = 1'b1;

    // Index of the final beat within a slot.
    localparam logic [CNT_W-1:0] LAST_BEAT = CNT_W'(BITS_PER_SLOT - 1);

    typedef struct packed {
        logic       kind;
        logic [9:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] pulse_width;
        logic       in_reset_gap;
        logic       last_of_slot;
    } t_out_item;

endpackage

`default_nettype wire

// ===== sv/lspwe_ram.sv =====
`default_nettype none

module lspwe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/led_strip_pulse_width_encoder_unit.sv =====
// Channel   Direction  Handshake                 Beat
// in        input      i_in_valid / o_in_ready   t_in_item: pixel write or slot request
// out       output     o_out_valid / i_out_ready t_out_item: one pulse width
// cfg       input      i_cfg_wr_en               i_cfg_index, i_cfg_data
//
// A slot produces 24 output beats, one per cycle while the sink is ready, so the
// output serializer sets the slot rate.
// A pixel slot reads its pixel through the store's registered read port when it is accepted and
// waits in a holding stage until the serializer finishes the previous slot.
// After reset the store is cleared one entry a cycle, all MAX_LEDS entries, with o_in_ready low.
// Output stalls hold the serializer; input stalls only while the store is cleared or the holding stage is full.
`default_nettype none

module led_strip_pulse_width_encoder_unit #(
    parameter int MAX_LEDS = lspwe_pkg::MAX_LEDS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire lspwe_pkg::t_in_item                 i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output lspwe_pkg::t_out_item                     o_out_data,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [lspwe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [lspwe_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int AW    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int EXT_W = 13;
    localparam logic [EXT_W-1:0] MAX_EXT  = EXT_W'(MAX_LEDS);
    localparam logic [AW-1:0]    CLR_LAST = AW'(MAX_LEDS - 1);
    localparam int PIX_W = 3 * 8;

    // Configuration registers.
    logic [7:0]                      r_high_one;
    logic [7:0]                      r_high_zero;
    logic [lspwe_pkg::POS_W-1:0]     r_led_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_one  <= lspwe_pkg::HIGH_ONE_RST;
            r_high_zero <= lspwe_pkg::HIGH_ZERO_RST;
            r_led_count <= lspwe_pkg::LED_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                lspwe_pkg::CFG_HIGH_ONE:  r_high_one  <= i_cfg_data[7:0];
                lspwe_pkg::CFG_HIGH_ZERO: r_high_zero <= i_cfg_data[7:0];
                lspwe_pkg::CFG_LED_COUNT: r_led_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control state.
    logic                            r_clr_busy;
    logic [AW-1:0]                   r_clr_addr;
    logic [lspwe_pkg::POS_W-1:0]     r_pos;
    logic                            r_gap_pending;
    logic                            r_s1_valid;
    logic                            r_s1_gap;
    logic                            r_ser_busy;
    logic                            r_ser_gap;
    logic [lspwe_pkg::CNT_W-1:0]     r_ser_cnt;
    logic [PIX_W-1:0]                r_ser_shift;

    logic [lspwe_pkg::POS_W-1:0]     n_pos;
    logic                            n_gap_pending;
    logic                            n_s1_valid;
    logic                            n_s1_gap;

    logic                            in_fire;
    logic                            slot_fire;
    logic                            pix_fire;
    logic                            beat_done;
    logic                            ser_last;
    logic                            ser_free;
    logic                            s1_load;
    logic                            at_end;
    logic                            rd_en;
    logic [EXT_W-1:0]                pos_ext;
    logic [EXT_W-1:0]                idx_ext;
    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [PIX_W-1:0]                ram_wdata;
    logic [PIX_W-1:0]                rd_data;

    // Handshake and serializer status.
    assign beat_done  = r_ser_busy && i_out_ready;
    assign ser_last   = (r_ser_cnt == lspwe_pkg::LAST_BEAT);
    assign ser_free   = !r_ser_busy || (beat_done && ser_last);
    assign s1_load    = r_s1_valid && ser_free;
    assign o_in_ready = !r_clr_busy && !(r_s1_valid && !ser_free);
    assign in_fire    = i_in_valid && o_in_ready;
    assign slot_fire  = in_fire && (i_in_data.kind == lspwe_pkg::KIND_SLOT);
    assign pix_fire   = in_fire && (i_in_data.kind == lspwe_pkg::KIND_WRITE);

    assign pos_ext = EXT_W'(r_pos);
    assign idx_ext = EXT_W'(i_in_data.pixel_index);
    assign at_end  = (r_pos >= r_led_count) || (pos_ext >= MAX_EXT);

    // Slot decode: gap slots need no store read.
    always_comb begin
        n_pos         = r_pos;
        n_gap_pending = r_gap_pending;
        n_s1_gap      = r_s1_gap;
        n_s1_valid    = s1_load ? 1'b0 : r_s1_valid;
        rd_en         = 1'b0;
        if (slot_fire) begin
            n_s1_valid = 1'b1;
            if (r_gap_pending) begin
                n_gap_pending = 1'b0;
                n_s1_gap      = 1'b1;
            end else if (at_end) begin
                n_gap_pending = 1'b1;
                n_pos         = '0;
                n_s1_gap      = 1'b1;
            end else begin
                n_pos    = r_pos + 1'b1;
                n_s1_gap = 1'b0;
                rd_en    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_gap_pending <= 1'b0;
            r_s1_valid    <= 1'b0;
            r_s1_gap      <= 1'b0;
        end else begin
            r_pos         <= n_pos;
            r_gap_pending <= n_gap_pending;
            r_s1_valid    <= n_s1_valid;
            r_s1_gap      <= n_s1_gap;
        end
    end

    // Clearing pass over the store after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == CLR_LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Store write port: clearing pass first, then pixel writes in range.
    always_comb begin
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = pix_fire && (idx_ext < MAX_EXT);
            ram_waddr = idx_ext[AW-1:0];
            ram_wdata = {i_in_data.green, i_in_data.red, i_in_data.blue};
        end
    end

    lspwe_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_LEDS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (pos_ext[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // Output serializer, most significant bit first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_busy <= 1'b0;
            r_ser_cnt  <= '0;
            r_ser_gap  <= 1'b0;
        end else if (s1_load) begin
            r_ser_busy <= 1'b1;
            r_ser_cnt  <= '0;
            r_ser_gap  <= r_s1_gap;
        end else if (beat_done) begin
            if (ser_last) begin
                r_ser_busy <= 1'b0;
            end else begin
                r_ser_cnt <= r_ser_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_ser_shift <= r_s1_gap ? '0 : rd_data;
        end else if (beat_done) begin
            r_ser_shift <= {r_ser_shift[PIX_W-2:0], 1'b0};
        end
    end

    // Output beat.
    assign o_out_valid             = r_ser_busy;
    assign o_out_data.pulse_width  = r_ser_gap ? 8'd0 :
                                     (r_ser_shift[PIX_W-1] ? r_high_one : r_high_zero);
    assign o_out_data.in_reset_gap = r_ser_gap;
    assign o_out_data.last_of_slot = ser_last;

endmodule

`default_nettype wire

// ===== sv/lspwe_checker.sv =====
`default_nettype none

module lspwe_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                o_in_ready,
    input wire logic                                o_out_valid,
    input wire logic                                i_out_ready,
    input wire lspwe_pkg::t_out_item                o_out_data
);

    // A stalled output beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // Reset gap beats carry no pulse.
    a_gap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.in_reset_gap |-> o_out_data.pulse_width == 8'd0)
        else $error("nonzero pulse width in reset gap");

    // A slot continues after a beat that is not its last, with the same gap flag.
    a_slot_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last_of_slot |=>
            o_out_valid && (o_out_data.in_reset_gap == $past(o_out_data.in_reset_gap)))
        else $error("slot ended early or changed kind");

    // Nothing moves right after reset; the store is still being cleared.
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("activity right after reset");

endmodule

bind led_strip_pulse_width_encoder_unit lspwe_checker u_lspwe_checker (.*);

`default_nettype wire

// ===== bench/led_strip_pulse_width_encoder_unit_test.sv =====
`timescale 1ns / 1ps

module led_strip_pulse_width_encoder_unit_test;

    localparam int MAX_LEDS      = lspwe_pkg::MAX_LEDS_DEF;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 400000;
    localparam int PRINT_LIMIT   = 40;

    // Index beyond the last register; a write there must change nothing.
    localparam logic [lspwe_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Clock, reset and the block's ports; the ones the bench drives are known from time zero.
    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                in_valid  = 1'b0;
    logic                                in_ready;
    lspwe_pkg::t_in_item                 in_data   = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    lspwe_pkg::t_out_item                out_data;
    logic                                cfg_wr_en = 1'b0;
    logic [lspwe_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [lspwe_pkg::CFG_W-1:0]         cfg_data  = '0;

    // Predictor copy of the encoder state and its registers.
    logic [23:0]                 pixel_mem [MAX_LEDS];
    logic [lspwe_pkg::POS_W-1:0] led_pos     = '0;
    bit                          gap_pending = 1'b0;
    logic [7:0]                  pulse_one   = lspwe_pkg::HIGH_ONE_RST;
    logic [7:0]                  pulse_zero  = lspwe_pkg::HIGH_ZERO_RST;
    logic [lspwe_pkg::POS_W-1:0] frame_leds  = lspwe_pkg::LED_COUNT_RST;

    // Items waiting to be sent and pulse beats waiting to come out.
    lspwe_pkg::t_in_item  pending_items [$];
    lspwe_pkg::t_out_item expected_pulses [$];

    int unsigned queued_count = 0;
    int unsigned taken_count  = 0;
    int unsigned error_count  = 0;

    // Idling controls shared between the sequence and the two sides.
    bit src_idle_on   = 1'b1;
    bit snk_idle_on   = 1'b1;
    bit hold_off_req  = 1'b0;
    bit in_took       = 1'b0;
    int src_gap       = 0;
    int snk_gap       = 0;
    int hold_left     = 0;

    led_strip_pulse_width_encoder_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 100 MHz clock.
    initial begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #30_000_000;
        $display("led_strip_pulse_width_encoder_unit regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (error_count < PRINT_LIMIT) begin
            $display("MISMATCH at %0t ns: %s got %0d want %0d", $time, what, got, want);
        end
        error_count++;
    endtask

    // Queue the 24 beats of one slot, either pixel bits or a reset gap.
    function automatic void push_slot(input bit gap, input logic [23:0] grb);
        lspwe_pkg::t_out_item beat;
        for (int k = 0; k < lspwe_pkg::BITS_PER_SLOT; k++) begin
            beat.pulse_width  = gap ? 8'd0 :
                                (grb[lspwe_pkg::BITS_PER_SLOT-1-k] ? pulse_one : pulse_zero);
            beat.in_reset_gap = gap;
            beat.last_of_slot = (k == lspwe_pkg::BITS_PER_SLOT - 1);
            expected_pulses.push_back(beat);
        end
    endfunction

    // Advance the predicted encoder by one accepted item.
    function automatic void encode_item(input lspwe_pkg::t_in_item item);
        if (item.kind == lspwe_pkg::KIND_WRITE) begin
            if (item.pixel_index < MAX_LEDS) begin
                pixel_mem[item.pixel_index] = {item.green, item.red, item.blue};
            end
        end else if (gap_pending) begin
            gap_pending = 1'b0;
            push_slot(1'b1, '0);
        end else if (led_pos >= frame_leds || led_pos >= MAX_LEDS) begin
            gap_pending = 1'b1;
            led_pos     = '0;
            push_slot(1'b1, '0);
        end else begin
            push_slot(1'b0, pixel_mem[led_pos]);
            led_pos = led_pos + 1'b1;
        end
    endfunction

    // Sender: a new beat is offered only once the previous one was taken.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_took) begin
            in_took = 1'b0;
            if (src_gap > 0) begin
                src_gap--;
                in_valid <= 1'b0;
            end else if (src_idle_on && $urandom_range(0, 9) == 0) begin
                src_gap = $urandom_range(1, 17) - 1;
                in_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                in_data  <= pending_items.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_off_req || hold_left > 0) begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end else begin
                hold_left--;
            end
            out_ready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            out_ready <= 1'b0;
        end else if (snk_idle_on && $urandom_range(0, 7) == 0) begin
            snk_gap = $urandom_range(1, 17) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Monitor: predict on every input beat, check every output beat.
    always @(posedge clk) begin
        lspwe_pkg::t_out_item want;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                in_took = 1'b1;
                taken_count++;
                encode_item(in_data);
            end
            if (out_valid && out_ready) begin
                if (expected_pulses.size() == 0) begin
                    report_mismatch("beat with nothing expected, pulse_width",
                                    out_data.pulse_width, 0);
                end else begin
                    want = expected_pulses.pop_front();
                    if (out_data.pulse_width !== want.pulse_width) begin
                        report_mismatch("pulse_width", out_data.pulse_width, want.pulse_width);
                    end
                    if (out_data.in_reset_gap !== want.in_reset_gap) begin
                        report_mismatch("in_reset_gap", out_data.in_reset_gap,
                                        want.in_reset_gap);
                    end
                    if (out_data.last_of_slot !== want.last_of_slot) begin
                        report_mismatch("last_of_slot", out_data.last_of_slot,
                                        want.last_of_slot);
                    end
                end
            end
        end
    end

    function automatic void offer_write(input logic [9:0] idx, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b);
        lspwe_pkg::t_in_item item;
        item.kind        = lspwe_pkg::KIND_WRITE;
        item.pixel_index = idx;
        item.red         = r;
        item.green       = g;
        item.blue        = b;
        pending_items.push_back(item);
        queued_count++;
    endfunction

    // Slot requests carry random values in the fields the block ignores.
    function automatic void offer_slot();
        lspwe_pkg::t_in_item item;
        item.kind        = lspwe_pkg::KIND_SLOT;
        item.pixel_index = 10'($urandom);
        item.red         = 8'($urandom);
        item.green       = 8'($urandom);
        item.blue        = 8'($urandom);
        pending_items.push_back(item);
        queued_count++;
    endfunction

    // Register write while idle; the predictor copy follows at once.
    task automatic write_register(input logic [lspwe_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [lspwe_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            lspwe_pkg::CFG_HIGH_ONE:  pulse_one  = value[7:0];
            lspwe_pkg::CFG_HIGH_ZERO: pulse_zero = value[7:0];
            lspwe_pkg::CFG_LED_COUNT: frame_leds = value;
            default: ;
        endcase
    endtask

    // Wait until every queued item is taken and every beat has come out.
    task automatic wait_drained();
        int spin;
        spin = 0;
        while ((taken_count != queued_count || expected_pulses.size() != 0)
               && spin < DRAIN_LIMIT) begin
            @(negedge clk);
            spin++;
        end
        if (taken_count != queued_count) begin
            report_mismatch("items never taken", queued_count - taken_count, 0);
        end
        if (expected_pulses.size() != 0) begin
            report_mismatch("beats still expected", expected_pulses.size(), 0);
            expected_pulses.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Frame-shaped random traffic: writes mostly up to the frame end, one in ten at any index, and slot requests.
    task automatic queue_frame_traffic(input int count);
        int span;
        span = (frame_leds > MAX_LEDS - 1) ? MAX_LEDS - 1 : frame_leds;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 40) begin
                offer_write(($urandom_range(0, 9) == 0) ? 10'($urandom)
                                                        : 10'($urandom_range(0, span)),
                            8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                offer_slot();
            end
        end
    endtask

    // Test sequence.
    initial begin
        int leds;
        for (int i = 0; i < MAX_LEDS; i++) begin
            pixel_mem[i] = '0;
        end
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Reset register values: mixed pixel, all ones, and a cleared entry.
        offer_write(10'd0, 8'h01, 8'h80, 8'hA5);
        offer_write(10'd1, 8'hFF, 8'hFF, 8'hFF);
        offer_write(10'd1023, 8'h55, 8'hAA, 8'h0F);
        offer_slot();
        offer_slot();
        offer_slot();
        wait_drained();

        // Widest pulse contrast and a three-LED frame; position is past the end.
        write_register(lspwe_pkg::CFG_HIGH_ONE, 11'h0FF);
        write_register(lspwe_pkg::CFG_HIGH_ZERO, 11'h700);
        write_register(lspwe_pkg::CFG_LED_COUNT, 11'd3);
        write_register(CFG_UNUSED, 11'h7FF);
        offer_slot();
        offer_slot();
        offer_slot();
        offer_write(10'd2, 8'h00, 8'hFF, 8'h00);
        offer_slot();
        offer_slot();
        offer_slot();
        offer_slot();
        wait_drained();

        // Empty frame: every slot is reset gap.
        write_register(lspwe_pkg::CFG_HIGH_ONE, 11'h000);
        write_register(lspwe_pkg::CFG_HIGH_ZERO, 11'h0FF);
        write_register(lspwe_pkg::CFG_LED_COUNT, 11'd0);
        offer_slot();
        offer_slot();
        offer_write(10'd0, 8'hFF, 8'h00, 8'hFF);
        offer_slot();
        wait_drained();

        // Single LED frame.
        write_register(lspwe_pkg::CFG_LED_COUNT, 11'd1);
        offer_slot();
        offer_slot();
        offer_slot();
        offer_slot();
        wait_drained();

        // Random phases, each with its own register setting and idling mix.
        for (int p = 0; p < 6; p++) begin
            leds = (p == 0) ? 1 : (p == 5) ? 12 : $urandom_range(2, 10);
            write_register(lspwe_pkg::CFG_HIGH_ONE, {3'($urandom), 8'($urandom)});
            write_register(lspwe_pkg::CFG_HIGH_ZERO, {3'($urandom), 8'($urandom)});
            write_register(lspwe_pkg::CFG_LED_COUNT, 11'(leds));
            src_idle_on = $urandom_range(0, 3) != 0;
            snk_idle_on = $urandom_range(0, 3) != 0;
            if (p == 2) begin
                // Back up the output so the block stalls its input.
                src_idle_on  = 1'b0;
                hold_off_req = 1'b1;
            end
            queue_frame_traffic(40);
            wait_drained();
        end

        // No idling from here on: a short frame with back-to-back items.
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        write_register(lspwe_pkg::CFG_LED_COUNT, 11'd7);
        write_register(lspwe_pkg::CFG_HIGH_ONE, 11'd49);
        write_register(lspwe_pkg::CFG_HIGH_ZERO, 11'd20);
        queue_frame_traffic(40);
        wait_drained();
        repeat (2 * lspwe_pkg::BITS_PER_SLOT) @(negedge clk);

        if (error_count == 0) begin
            $display("led_strip_pulse_width_encoder_unit regression: pass");
        end else begin
            $display("led_strip_pulse_width_encoder_unit regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/lspwe_pkg.sv
sv/lspwe_ram.sv
sv/led_strip_pulse_width_encoder_unit.sv
sv/lspwe_checker.sv
bench/led_strip_pulse_width_encoder_unit_test.sv
